FILE: hdl/shk_pkg.sv
// ----------------------------------------------------------------------------
// shk_pkg: shared types and constants for the SHAKE128 sponge
// Command and status structs between controller and datapath, register codes.
// ----------------------------------------------------------------------------
`default_nettype none
package shk_pkg;

   localparam int unsigned NUM_ROUNDS = 24;
   localparam logic [7:0]  LFSR_POLY  = 8'h71;
   localparam logic [7:0]  PAD_BYTE   = 8'h80;
   localparam logic [7:0]  RATE_MAX   = 8'd199;

   localparam logic [1:0] REG_RATE   = 2'd0;
   localparam logic [1:0] REG_SUFFIX = 2'd1;
   localparam logic [1:0] REG_OUTLEN = 2'd2;

   // byte-op selector for the datapath
   typedef enum logic [1:0] {
      BOP_NONE,
      BOP_XOR,
      BOP_CLEAR
   } byte_op_type;

   typedef struct packed {
      byte_op_type op;       // XOR a byte, clear state, or nothing
      logic [7:0]  pos;      // byte position
      logic [7:0]  value;    // byte to XOR
      logic        perm_start;
   } dp_cmd_type;

   typedef struct packed {
      logic       perm_busy;
      logic [7:0] rd_byte;   // byte at cmd.pos, combinational
   } dp_sts_type;

endpackage
`default_nettype wire

FILE: hdl/shk_datapath.sv
// ----------------------------------------------------------------------------
// shk_datapath: Keccak state and round unit
// Holds the 25-lane state, applies byte XORs and clears, and runs one round per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module shk_datapath
   import shk_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire dp_cmd_type cmd,
   output dp_sts_type      sts
);

   logic [63:0] lane_ff [25];
   logic [63:0] lane_in [25];
   logic [63:0] rnd     [25];
   logic        busy_ff, busy_in;
   logic [4:0]  round_ff, round_in;
   logic [7:0]  lfsr_ff, lfsr_in;
   logic [63:0] rc;
   logic [7:0]  lfsr_walk;

   function automatic logic [63:0] rol(input logic [63:0] v, input int n);
      rol = (n == 0) ? v : ((v << n) | (v >> (64 - n)));
   endfunction

   function automatic int rho_off(input int x, input int y);
      int px, py, nx, r;
      rho_off = 0;
      px = 1; py = 0; r = 0;
      for (int s = 0; s < 24; s++) begin
         r = r + s + 1;
         if (px == x && py == y) rho_off = r % 64;
         nx = py;
         py = (2*px + 3*py) % 5;
         px = nx;
      end
   endfunction

   // round constant from the LFSR, seven steps
   always_comb begin
      rc        = '0;
      lfsr_walk = lfsr_ff;
      for (int j = 0; j < 7; j++) begin
         lfsr_walk = {lfsr_walk[6:0], 1'b0} ^ (lfsr_walk[7] ? LFSR_POLY : 8'h00);
         if (lfsr_walk[1]) rc[(1 << j) - 1] = 1'b1;
      end
   end

   // one Keccak-f round
   always_comb begin
      logic [63:0] c [5];
      logic [63:0] t [25];
      logic [63:0] b [25];
      for (int x = 0; x < 5; x++)
         c[x] = lane_ff[x] ^ lane_ff[x+5] ^ lane_ff[x+10] ^ lane_ff[x+15] ^ lane_ff[x+20];
      for (int x = 0; x < 5; x++)
         for (int y = 0; y < 5; y++)
            t[x+5*y] = lane_ff[x+5*y] ^ c[(x+4)%5] ^ rol(c[(x+1)%5], 1);
      // rho and pi: b[y, 2x+3y] = rol(t[x,y], r[x,y])
      for (int x = 0; x < 5; x++)
         for (int y = 0; y < 5; y++)
            b[y + 5*((2*x+3*y)%5)] = rol(t[x+5*y], rho_off(x, y));
      for (int y = 0; y < 5; y++)
         for (int x = 0; x < 5; x++)
            rnd[x+5*y] = b[x+5*y] ^ (~b[(x+1)%5+5*y] & b[(x+2)%5+5*y]);
      rnd[0] = rnd[0] ^ rc;
   end

   // byte read
   always_comb begin
      sts.perm_busy = busy_ff;
      sts.rd_byte   = 8'h00;
      if (cmd.pos < 8'd200)
         sts.rd_byte = lane_ff[cmd.pos[7:3]][8*cmd.pos[2:0] +: 8];
   end

   // state update
   always_comb begin
      for (int i = 0; i < 25; i++) lane_in[i] = lane_ff[i];
      busy_in  = busy_ff;
      round_in = round_ff;
      lfsr_in  = lfsr_ff;
      if (busy_ff) begin
         for (int i = 0; i < 25; i++) lane_in[i] = rnd[i];
         lfsr_in  = lfsr_walk;
         round_in = round_ff + 5'd1;
         if (round_ff == 5'(NUM_ROUNDS - 1)) busy_in = 1'b0;
      end else begin
         case (cmd.op)
            BOP_XOR: begin
               if (cmd.pos < 8'd200)
                  lane_in[cmd.pos[7:3]][8*cmd.pos[2:0] +: 8] =
                     lane_ff[cmd.pos[7:3]][8*cmd.pos[2:0] +: 8] ^ cmd.value;
            end
            BOP_CLEAR: for (int i = 0; i < 25; i++) lane_in[i] = '0;
            default: ;
         endcase
         if (cmd.perm_start) begin
            busy_in  = 1'b1;
            round_in = '0;
            lfsr_in  = 8'h01;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 25; i++) lane_ff[i] <= '0;
         busy_ff  <= 1'b0;
         round_ff <= '0;
         lfsr_ff  <= 8'h01;
      end else begin
         for (int i = 0; i < 25; i++) lane_ff[i] <= lane_in[i];
         busy_ff  <= busy_in;
         round_ff <= round_in;
         lfsr_ff  <= lfsr_in;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/shk_control.sv
// ----------------------------------------------------------------------------
// shk_control: sponge sequencer
// Absorbs bytes, pads, squeezes and clears, driving the datapath by command.
// ----------------------------------------------------------------------------
`default_nettype none
module shk_control
   import shk_pkg::*;
#(
   parameter int unsigned MAX_OUT_BYTES = 64
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic [7:0] rate_bytes,
   input  wire logic [7:0] domain_suffix,
   input  wire logic [6:0] out_length,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_data,
   input  wire logic       req_carries,
   input  wire logic       req_last,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_data,
   output logic            rsp_last,
   output dp_cmd_type      cmd,
   input  wire dp_sts_type sts
);

   typedef enum logic [3:0] {
      S_IDLE, S_PRE, S_ABS, S_ABSW, S_SFX, S_SFXW, S_PAD, S_PADW,
      S_SQZ, S_SQZW, S_OUT, S_CLR
   } state_type;

   localparam logic [6:0] MAX_OUT = 7'(MAX_OUT_BYTES);

   state_type  state_ff;
   logic [7:0] fill_ff, pos_ff, byte_ff;
   logic       carry_ff, last_ff;
   logic [6:0] cnt_ff, olen_ff;
   logic [7:0] rate;
   logic [6:0] olen;

   // effective rate and digest length
   always_comb begin
      rate = rate_bytes;
      if (rate == 8'd0) rate = 8'd1;
      if (rate > RATE_MAX) rate = RATE_MAX;
      olen = (out_length > MAX_OUT) ? MAX_OUT : out_length;
   end

   // next item only once a pending permutation has finished
   assign req_tready = (state_ff == S_IDLE) && !sts.perm_busy;

   // command generation
   always_comb begin
      cmd.op         = BOP_NONE;
      cmd.pos        = pos_ff;
      cmd.value      = byte_ff;
      cmd.perm_start = 1'b0;
      case (state_ff)
         S_PRE:  cmd.perm_start = (fill_ff >= rate);
         S_ABS: begin
            cmd.op  = carry_ff ? BOP_XOR : BOP_NONE;
            cmd.pos = fill_ff;
            cmd.perm_start = carry_ff && (fill_ff + 8'd1 >= rate);
         end
         S_SFX: begin
            cmd.op = BOP_XOR; cmd.pos = fill_ff; cmd.value = domain_suffix;
            cmd.perm_start = domain_suffix[7] && (fill_ff == rate - 8'd1);
         end
         S_PAD: begin
            cmd.op = BOP_XOR; cmd.pos = rate - 8'd1; cmd.value = PAD_BYTE;
            cmd.perm_start = 1'b1;
         end
         S_SQZ:  cmd.perm_start = (pos_ff == rate);
         S_CLR:  cmd.op = BOP_CLEAR;
         default: ;
      endcase
   end

   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_data   = byte_ff;
   assign rsp_last   = (cnt_ff + 7'd1 == olen_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff  <= '0;
         pos_ff   <= '0;
         cnt_ff   <= '0;
         olen_ff  <= '0;
      end else begin
         case (state_ff)
            S_IDLE: if (req_tvalid && req_tready) begin
               byte_ff  <= req_data;
               carry_ff <= req_carries;
               last_ff  <= req_last;
               state_ff <= S_PRE;
            end
            S_PRE: begin
               if (fill_ff >= rate) fill_ff <= '0;
               state_ff <= S_ABSW;
            end
            S_ABSW: if (!sts.perm_busy) state_ff <= S_ABS;
            S_ABS: begin
               if (carry_ff)
                  fill_ff <= (fill_ff + 8'd1 >= rate) ? 8'd0 : fill_ff + 8'd1;
               state_ff <= last_ff ? S_SFXW : S_IDLE;
            end
            S_SFXW: if (!sts.perm_busy) state_ff <= S_SFX;
            S_SFX:  state_ff <= S_PADW;
            S_PADW: if (!sts.perm_busy) state_ff <= S_PAD;
            S_PAD: begin
               pos_ff   <= '0;
               cnt_ff   <= '0;
               olen_ff  <= olen;
               state_ff <= S_SQZW;
            end
            S_SQZW: if (!sts.perm_busy)
               state_ff <= (cnt_ff == olen_ff) ? S_CLR : S_SQZ;
            S_SQZ: begin
               if (pos_ff == rate) begin
                  pos_ff   <= '0;
                  state_ff <= S_SQZW;
               end else begin
                  byte_ff  <= sts.rd_byte;
                  pos_ff   <= pos_ff + 8'd1;
                  state_ff <= S_OUT;
               end
            end
            S_OUT: if (rsp_tready) begin
               cnt_ff   <= cnt_ff + 7'd1;
               state_ff <= (cnt_ff + 7'd1 == olen_ff) ? S_CLR : S_SQZ;
            end
            S_CLR: begin
               fill_ff  <= '0;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

FILE: hdl/shake128_sponge_hash_top.sv
// ----------------------------------------------------------------------------
// shake128_sponge_hash_top: byte-serial SHAKE128 sponge
// Absorbs message bytes, pads on the last item and streams the digest.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries at most one message byte per transfer (tdata = data_byte,
//   carries_byte; tlast = is_last). rsp_* returns digest bytes, tlast on
//   the final one. csr_* writes rate, suffix and digest length; the user must
//   write them only while idle, the block does not enforce it. An item
//   passes S_PRE, S_ABSW and S_ABS; when a byte fills the rate a permutation
//   follows (one round per cycle in the datapath round unit) and the next
//   item is accepted once it has finished. A last item adds padding with
//   one or two permutations, then streams the digest, with a permutation
//   per extra rate block, and clears in S_CLR. Reset zeroes the state and
//   loads the default registers (SHAKE128, 32 bytes). While rsp_tready is low
//   the held byte waits and no new item is accepted until the digest is drained.
// ----------------------------------------------------------------------------
`default_nettype none
module shake128_sponge_hash_top
   import shk_pkg::*;
#(
   parameter int unsigned MAX_OUT_BYTES = 64
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [15:0] req_tdata,  // [7:0] data_byte, [8] carries_byte
   input  wire logic       req_tlast,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] out_byte
   output logic            rsp_tlast,
   input  wire logic       csr_we,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_wdata
);

   logic [7:0] rate_ff, sfx_ff;
   logic [6:0] olen_ff;
   dp_cmd_type cmd;
   dp_sts_type sts;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= 8'd168;
         sfx_ff  <= 8'h1F;
         olen_ff <= 7'd32;
      end else if (csr_we) begin
         case (csr_index)
            REG_RATE:   rate_ff <= csr_wdata;
            REG_SUFFIX: sfx_ff  <= csr_wdata;
            REG_OUTLEN: olen_ff <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   shk_control #(.MAX_OUT_BYTES(MAX_OUT_BYTES)) u_ctrl (
      .clock, .reset,
      .rate_bytes(rate_ff), .domain_suffix(sfx_ff), .out_length(olen_ff),
      .req_tvalid, .req_tready,
      .req_data(req_tdata[7:0]), .req_carries(req_tdata[8]), .req_last(req_tlast),
      .rsp_tvalid, .rsp_tready, .rsp_data(rsp_tdata), .rsp_last(rsp_tlast),
      .cmd, .sts
   );

   shk_datapath u_dp (.clock, .reset, .cmd, .sts);

endmodule
`default_nettype wire

FILE: tb/sv/shake128_sponge_hash_top_test.sv
// ----------------------------------------------------------------------------
// shake128_sponge_hash_top_test: self-checking regression for the sponge
// Streams messages into the block and predicts each digest byte with a
// behavioral Keccak sponge. Covers rate, suffix and digest length settings,
// and random idling and stalls on both channels.
// ----------------------------------------------------------------------------
`default_nettype none
module shake128_sponge_hash_top_test
   import shk_pkg::*;
();

   localparam int unsigned DIGEST_MAX = 64;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
   } digest_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;     // [7:0] data_byte, [8] carries_byte
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;          // [7:0] out_byte
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = REG_RATE;
   logic [7:0]  csr_wdata = '0;

   // predictor state
   logic [63:0] lanes [25];
   int unsigned fill;
   logic [7:0]  rate_reg;
   logic [7:0]  sfx_reg;
   logic [6:0]  olen_reg;

   digest_byte_type digest_q[$];
   int unsigned     mismatches = 0;
   bit              sink_hold = 1'b0;
   bit              quiet_mode = 1'b0;

   shake128_sponge_hash_top #(.MAX_OUT_BYTES(DIGEST_MAX)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic logic [63:0] rol64(logic [63:0] v, int unsigned n);
      n = n % 64;
      return (n == 0) ? v : ((v << n) | (v >> (64 - n)));
   endfunction

   // Keccak-f[1600], round constants from the 8-bit LFSR
   task automatic keccak_f();
      logic [63:0] c[5];
      logic [63:0] row[5];
      logic [63:0] d, cur, tmp;
      int unsigned x, y, nx, rot;
      logic [7:0]  lfsr;
      lfsr = 8'd1;
      for (int r = 0; r < NUM_ROUNDS; r++) begin
         for (int i = 0; i < 5; i++)
            c[i] = lanes[i] ^ lanes[i+5] ^ lanes[i+10] ^ lanes[i+15] ^ lanes[i+20];
         for (int i = 0; i < 5; i++) begin
            d = c[(i+4)%5] ^ rol64(c[(i+1)%5], 1);
            for (int j = 0; j < 5; j++) lanes[i+5*j] ^= d;
         end
         x = 1; y = 0; rot = 0;
         cur = lanes[1];
         for (int t = 0; t < 24; t++) begin
            rot += t + 1;
            nx = y;
            y = (2*x + 3*y) % 5;
            x = nx;
            tmp = lanes[x+5*y];
            lanes[x+5*y] = rol64(cur, rot);
            cur = tmp;
         end
         for (int j = 0; j < 5; j++) begin
            for (int i = 0; i < 5; i++) row[i] = lanes[i+5*j];
            for (int i = 0; i < 5; i++)
               lanes[i+5*j] = row[i] ^ (~row[(i+1)%5] & row[(i+2)%5]);
         end
         for (int j = 0; j < 7; j++) begin
            lfsr = {lfsr[6:0], 1'b0} ^ (lfsr[7] ? LFSR_POLY : 8'h00);
            if (lfsr[1]) lanes[0][(1 << j) - 1] ^= 1'b1;
         end
      end
   endtask

   task automatic mix_byte(int unsigned pos, logic [7:0] b);
      if (pos < 200) lanes[pos/8][8*(pos%8) +: 8] ^= b;
   endtask

   task automatic sponge_reset();
      foreach (lanes[i]) lanes[i] = '0;
      fill = 0;
   endtask

   // absorb one item; on a last item queue the whole digest
   task automatic sponge_absorb(logic [7:0] data, bit has_byte, bit last);
      int unsigned rate, olen, pos;
      digest_byte_type e;
      rate = (rate_reg == 0) ? 1 : (rate_reg > RATE_MAX) ? RATE_MAX : rate_reg;
      olen = (olen_reg > DIGEST_MAX) ? DIGEST_MAX : olen_reg;
      if (fill >= rate) begin
         keccak_f();
         fill = 0;
      end
      if (has_byte) begin
         mix_byte(fill, data);
         fill++;
         if (fill >= rate) begin
            keccak_f();
            fill = 0;
         end
      end
      if (!last) return;
      mix_byte(fill, sfx_reg);
      if (sfx_reg[7] && fill == rate - 1) keccak_f();
      mix_byte(rate - 1, PAD_BYTE);
      keccak_f();
      pos = 0;
      for (int k = 0; k < olen; k++) begin
         if (pos == rate) begin
            keccak_f();
            pos = 0;
         end
         e.out_byte  = (pos < 200) ? lanes[pos/8][8*(pos%8) +: 8] : 8'h00;
         e.last_byte = (k + 1 == olen);
         digest_q.push_back(e);
         pos++;
      end
      sponge_reset();
   endtask

   // result checker and receiver backpressure
   always @(posedge clock) begin
      digest_byte_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.out_byte  = rsp_tdata;
         got.last_byte = rsp_tlast;
         if (digest_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected digest byte %h", rsp_tdata);
         end else begin
            want = digest_q.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("digest mismatch: expected byte %h last %b, got byte %h last %b",
                           want.out_byte, want.last_byte, got.out_byte, got.last_byte);
            end
         end
      end
      rsp_tready <= !reset && !sink_hold && (quiet_mode || $urandom_range(99) >= 23);
   end

   task automatic wait_cycles(int n);
      repeat (n) @(posedge clock);
   endtask

   // one transfer on the request channel with random idle first;
   // tvalid stays up so back-to-back items need no gap
   task automatic send_item(logic [7:0] data, bit has_byte, bit last);
      while (!quiet_mode && $urandom_range(99) < 23) begin
         req_tvalid <= 1'b0;
         wait_cycles(1);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, has_byte, data};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      sponge_absorb(data, has_byte, last);
   endtask

   task automatic send_message(int n, bit empty_tail);
      for (int i = 0; i < n; i++)
         send_item(8'($urandom_range(255)), 1'b1, (i == n - 1) && !empty_tail);
      if (empty_tail) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (digest_q.size() != 0) wait_cycles(1);
      wait_cycles(200);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [7:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      wait_cycles(1);
      csr_we <= 1'b0;
      wait_cycles(1);
      case (idx)
         REG_RATE:   rate_reg = val;
         REG_SUFFIX: sfx_reg  = val;
         REG_OUTLEN: olen_reg = val[6:0];
         default: ;
      endcase
   endtask

   task automatic configure(logic [7:0] rate, logic [7:0] sfx, logic [7:0] olen);
      drain();
      write_reg(REG_RATE, rate);
      write_reg(REG_SUFFIX, sfx);
      write_reg(REG_OUTLEN, olen);
   endtask

   // default SHAKE128: empty message, byte extremes, two-byte message
   task automatic test_defaults();
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'hFF, 1'b1, 1'b1);
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'hA5, 1'b1, 1'b1);
   endtask

   // small, zero and out-of-range rates, suffix with top bit at rate-1, long and empty digests
   task automatic test_padding_corners();
      configure(8'd1, 8'h80, 8'd64);
      send_item(8'h5A, 1'b0, 1'b1);
      configure(8'd3, 8'hFF, 8'd1);
      send_item(8'h11, 1'b1, 1'b0);
      send_item(8'h22, 1'b1, 1'b1);
      configure(8'd0, 8'h00, 8'd0);
      send_item(8'h33, 1'b1, 1'b1);
      send_item(8'h00, 1'b0, 1'b0);
      configure(8'd255, 8'h06, 8'd127);
      send_message(3, 1'b0);
      configure(8'd199, 8'h1F, 8'd70);
      send_message(2, 1'b1);
   endtask

   // lower the rate with a partially filled state
   task automatic test_rate_drop();
      configure(8'd8, 8'h1F, 8'd9);
      for (int i = 0; i < 6; i++) send_item(8'($urandom_range(255)), 1'b1, 1'b0);
      drain();
      write_reg(REG_RATE, 8'd4);
      send_item(8'hC3, 1'b1, 1'b1);
   endtask

   // receiver stalls long while the sender keeps offering
   task automatic test_backpressure();
      configure(8'd5, 8'h9F, 8'd20);
      sink_hold = 1'b1;
      fork
         begin
            send_message(6, 1'b0);
            send_message(4, 1'b0);
         end
         begin
            wait_cycles(600);
            sink_hold = 1'b0;
         end
      join
   endtask

   // random messages with random settings and a quiet stretch
   task automatic test_random();
      int n;
      for (int m = 0; m < 16; m++) begin
         if (m % 4 == 0)
            configure(8'($urandom_range(1, 24)), 8'($urandom_range(255)),
                      8'($urandom_range(1, 16)));
         quiet_mode = (m >= 8 && m < 12);
         n = $urandom_range(1, 10);
         send_message(n, $urandom_range(3) == 0);
         if (m == 15) drain();
      end
      quiet_mode = 1'b0;
   endtask

   initial begin
      sponge_reset();
      rate_reg = 8'd168;
      sfx_reg  = 8'h1F;
      olen_reg = 7'd32;
      wait_cycles(4);
      reset <= 1'b0;
      wait_cycles(1);
      test_defaults();
      test_padding_corners();
      test_rate_drop();
      test_backpressure();
      test_random();
      drain();
      if (mismatches == 0 && digest_q.size() == 0)
         $display("shake128_sponge_hash_top regression: pass");
      else
         $display("shake128_sponge_hash_top regression: fail");
      $finish;
   end

   initial begin
      #2000000;
      $display("shake128_sponge_hash_top regression: fail");
      $finish;
   end

endmodule
`default_nettype wire

FILE: files.f
hdl/shk_pkg.sv
hdl/shk_datapath.sv
hdl/shk_control.sv
hdl/shake128_sponge_hash_top.sv
tb/sv/shake128_sponge_hash_top_test.sv
